// File: hw/rtl/sje_pkg.sv
// ----------------------------------------------------------------------------
// sje_pkg
// Shared types and codes for the surjection enumerator: the stack entry
// held by each cell, the per-cell operation codes and the stack command.
// ----------------------------------------------------------------------------
package sje_pkg;

    localparam int SIZE_W = 5;

    typedef logic [SIZE_W-1:0] size_t;

    // One stack entry: a digit, whether that digit was new with respect to
    // the levels below it when it was pushed, and an occupied flag.
    typedef struct packed {
        size_t digit;
        logic  fresh;
        logic  occ;
    } entry_t;

    typedef logic [1:0] cell_op_t;

    localparam cell_op_t CELL_HOLD      = 2'd0;
    localparam cell_op_t CELL_TAKE_UP   = 2'd1;
    localparam cell_op_t CELL_TAKE_DOWN = 2'd2;
    localparam cell_op_t CELL_CLEAR     = 2'd3;

    typedef logic [2:0] stack_op_t;

    localparam stack_op_t STK_HOLD = 3'd0;
    localparam stack_op_t STK_SET  = 3'd1;
    localparam stack_op_t STK_PUSH = 3'd2;
    localparam stack_op_t STK_POP  = 3'd3;
    localparam stack_op_t STK_INIT = 3'd4;

    // top goes into the top cell; under goes into the second cell on a push.
    typedef struct packed {
        stack_op_t op;
        entry_t    top;
        entry_t    under;
    } stack_cmd_t;

endpackage

// File: hw/rtl/sje_cell.sv
// ----------------------------------------------------------------------------
// sje_cell
// One level of the digit stack. Takes its entry from the neighbor above on
// a push, from the neighbor below on a pop, and compares its digit against
// the broadcast candidate.
// ----------------------------------------------------------------------------
module sje_cell
    import sje_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cell_op_t op,
    input  entry_t   from_up,
    input  entry_t   from_down,
    input  size_t    cand,
    output entry_t   cur,
    output logic     hit
);

    logic  occ_reg;
    logic  occ_next;
    size_t digit_reg;
    size_t digit_next;
    logic  fresh_reg;
    logic  fresh_next;

    always_comb
    begin
        occ_next   = occ_reg;
        digit_next = digit_reg;
        fresh_next = fresh_reg;
        case (op)
            CELL_HOLD:
            begin
                occ_next = occ_reg;
            end
            CELL_TAKE_UP:
            begin
                occ_next   = from_up.occ;
                digit_next = from_up.digit;
                fresh_next = from_up.fresh;
            end
            CELL_TAKE_DOWN:
            begin
                occ_next   = from_down.occ;
                digit_next = from_down.digit;
                fresh_next = from_down.fresh;
            end
            CELL_CLEAR:
            begin
                occ_next = 1'b0;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        fresh_reg <= fresh_next;
    end

    assign cur = '{digit: digit_reg, fresh: fresh_reg, occ: occ_reg};
    assign hit = occ_reg & (digit_reg == cand);

endmodule

// File: hw/rtl/sje_stack.sv
// ----------------------------------------------------------------------------
// sje_stack
// Backtracking digit stack built as a row of cells with the current level
// in the first cell. Reports whether the candidate digit already appears
// in the levels below the top.
// ----------------------------------------------------------------------------
module sje_stack
    import sje_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  stack_cmd_t cmd,
    input  size_t      cand,
    output entry_t     top,
    output logic       under_fresh,
    output logic       prefix_hit
);

    entry_t           cell_q [DEPTH];
    logic [DEPTH-1:0] hit_v;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        entry_t   up_e;
        entry_t   down_e;
        cell_op_t cell_op;

        if (k == 0)
        begin : g_up_top
            assign up_e = cmd.top;
        end
        else if (k == 1)
        begin : g_up_under
            assign up_e = cmd.under;
        end
        else
        begin : g_up_chain
            assign up_e = cell_q[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_down_end
            assign down_e = '0;
        end
        else
        begin : g_down_chain
            assign down_e = cell_q[k+1];
        end

        always_comb
        begin
            case (cmd.op)
                STK_HOLD: cell_op = CELL_HOLD;
                STK_SET:  cell_op = (k == 0) ? CELL_TAKE_UP : CELL_HOLD;
                STK_PUSH: cell_op = CELL_TAKE_UP;
                STK_POP:  cell_op = CELL_TAKE_DOWN;
                STK_INIT: cell_op = (k == 0) ? CELL_TAKE_UP : CELL_CLEAR;
                default:  cell_op = CELL_HOLD;
            endcase
        end

        sje_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (cell_op),
            .from_up   (up_e),
            .from_down (down_e),
            .cand      (cand),
            .cur       (cell_q[k]),
            .hit       (hit_v[k])
        );
    end

    assign top = cell_q[0];

    if (DEPTH > 1)
    begin : g_under
        assign under_fresh = cell_q[1].fresh;
    end
    else
    begin : g_no_under
        assign under_fresh = 1'b0;
    end

    // The top cell holds the digit under test, so only the levels below count.
    assign prefix_hit = |(hit_v >> 1);

endmodule

// File: hw/rtl/surjection_enumerator.sv
// A request moves the sequencer from idle into the search, which takes one digit
// step per cycle in the cell stack; the tuple is then moved level by level into
// the emit chain and sent out as n beats, each of which waits for the output.
// Only one request is handled at a time; the next is taken once the last beat
// has been registered. Reset (rst_n low, asynchronous) returns the sizes
// to 3 and 2 and starts the enumeration from the first tuple.
// ----------------------------------------------------------------------------
// surjection_enumerator
// Enumerates the surjective functions from domain_size points onto
// codomain_size values in lexicographic order: one tuple, or a done beat, per request.
// ----------------------------------------------------------------------------
module surjection_enumerator
    import sje_pkg::*;
#(
    parameter int MAX_DOMAIN   = 16,
    parameter int MAX_CODOMAIN = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              restart,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SIZE_W-1:0] position,
    output logic [SIZE_W-1:0] image_value,
    output logic              last_of_tuple,
    output logic              done_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SIZE_MAX = (1 << SIZE_W) - 1;
    localparam int N_CAP    = (MAX_DOMAIN > SIZE_MAX) ? SIZE_MAX : MAX_DOMAIN;
    localparam int M_CAP    = (MAX_CODOMAIN > SIZE_MAX) ? SIZE_MAX : MAX_CODOMAIN;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_XFER   = 3'd2;
    localparam logic [2:0] ST_EMIT   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic REG_DOMAIN   = 1'b0;
    localparam logic REG_CODOMAIN = 1'b1;

    // Configuration registers.
    size_t dom_reg;
    size_t cod_reg;
    logic  wr_en;

    // Control state.
    logic [2:0] state_reg;
    logic [2:0] state_next;
    size_t      lvl_reg;
    size_t      lvl_next;
    size_t      miss_reg;
    size_t      miss_next;
    size_t      cnt_reg;
    size_t      cnt_next;
    logic       init_reg;
    logic       init_next;
    logic       exh_reg;
    logic       exh_next;
    logic       ovalid_reg;
    logic       ovalid_next;

    // Output beat payload.
    size_t opos_reg;
    size_t opos_next;
    size_t oval_reg;
    size_t oval_next;
    logic  olast_reg;
    logic  olast_next;
    logic  odone_reg;
    logic  odone_next;

    // Emit chain, top at index 0.
    size_t och_digit_reg [MAX_DOMAIN];
    logic  och_fresh_reg [MAX_DOMAIN];
    logic  och_push;
    logic  och_pop;

    // Stack interface and search arithmetic.
    stack_cmd_t stk_cmd;
    entry_t     stk_top;
    logic       stk_under_fresh;
    logic       stk_hit;
    size_t      cand;
    size_t      n_eff;
    size_t      m_eff;
    size_t      miss_after;
    size_t      room;
    logic       can_inc;
    logic       ok;
    logic       in_acc;
    logic       out_free;
    logic       start;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dom_reg <= SIZE_W'(3);
            cod_reg <= SIZE_W'(2);
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_DOMAIN)
            begin
                dom_reg <= pwdata[SIZE_W-1:0];
            end
            else
            begin
                cod_reg <= pwdata[SIZE_W-1:0];
            end
        end
    end

    assign prdata = {{(32-SIZE_W){1'b0}}, (paddr[2] == REG_CODOMAIN) ? cod_reg : dom_reg};

    always_comb
    begin
        if (dom_reg == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (dom_reg > N_CAP)
        begin
            n_eff = SIZE_W'(N_CAP);
        end
        else
        begin
            n_eff = dom_reg;
        end

        if (cod_reg == '0)
        begin
            m_eff = SIZE_W'(1);
        end
        else if (cod_reg > M_CAP)
        begin
            m_eff = SIZE_W'(M_CAP);
        end
        else
        begin
            m_eff = cod_reg;
        end
    end

    // ------------------------------------------------------------------
    // Digit stack
    // ------------------------------------------------------------------
    sje_stack #(
        .DEPTH (MAX_DOMAIN)
    ) u_stack (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (stk_cmd),
        .cand        (cand),
        .top         (stk_top),
        .under_fresh (stk_under_fresh),
        .prefix_hit  (stk_hit)
    );

    assign cand    = SIZE_W'(stk_top.digit + 1'b1);
    assign can_inc = stk_top.digit < m_eff;
    // A candidate that is not yet in the prefix covers one more value.
    assign miss_after = SIZE_W'(miss_reg - {{(SIZE_W-1){1'b0}}, ~stk_hit});
    assign room       = SIZE_W'(n_eff - lvl_reg);
    assign ok         = miss_after <= room;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid & in_ready;
    assign out_free = ~ovalid_reg | out_ready;
    assign start    = restart | init_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        lvl_next    = lvl_reg;
        miss_next   = miss_reg;
        cnt_next    = cnt_reg;
        init_next   = init_reg;
        exh_next    = exh_reg;
        ovalid_next = ovalid_reg & ~out_ready;
        opos_next   = opos_reg;
        oval_next   = oval_reg;
        olast_next  = olast_reg;
        odone_next  = odone_reg;
        och_push    = 1'b0;
        och_pop     = 1'b0;
        stk_cmd     = '{op: STK_HOLD, top: '0, under: '0};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (start)
                    begin
                        stk_cmd.op  = STK_INIT;
                        stk_cmd.top = '{digit: '0, fresh: 1'b0, occ: 1'b1};
                        lvl_next    = SIZE_W'(1);
                        miss_next   = m_eff;
                        init_next   = 1'b0;
                        exh_next    = 1'b0;
                    end
                    if ((exh_reg & ~start) | (m_eff > n_eff))
                    begin
                        state_next = ST_FINISH;
                        exh_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = ST_FINISH;
                    exh_next   = 1'b1;
                end
                else if (!can_inc)
                begin
                    // Backtrack: the level below becomes current and leaves the prefix.
                    stk_cmd.op = STK_POP;
                    lvl_next   = SIZE_W'(lvl_reg - 1'b1);
                    if (lvl_reg > SIZE_W'(1))
                    begin
                        miss_next = SIZE_W'(miss_reg + {{(SIZE_W-1){1'b0}}, stk_under_fresh});
                    end
                end
                else if (ok && (lvl_reg == n_eff))
                begin
                    stk_cmd.op  = STK_SET;
                    stk_cmd.top = '{digit: cand, fresh: 1'b0, occ: 1'b1};
                    state_next  = ST_XFER;
                    cnt_next    = '0;
                end
                else if (ok)
                begin
                    stk_cmd.op    = STK_PUSH;
                    stk_cmd.top   = '{digit: '0, fresh: 1'b0, occ: 1'b1};
                    stk_cmd.under = '{digit: cand, fresh: ~stk_hit, occ: 1'b1};
                    lvl_next      = SIZE_W'(lvl_reg + 1'b1);
                    miss_next     = miss_after;
                end
                else
                begin
                    stk_cmd.op  = STK_SET;
                    stk_cmd.top = '{digit: cand, fresh: 1'b0, occ: 1'b1};
                end
            end
            ST_XFER:
            begin
                // Pop the tuple into the emit chain so the first point ends on top.
                stk_cmd.op = STK_POP;
                och_push   = 1'b1;
                cnt_next   = SIZE_W'(cnt_reg + 1'b1);
                if (cnt_reg == SIZE_W'(n_eff - 1'b1))
                begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    // Each beat goes back onto the stack, which restores it.
                    ovalid_next   = 1'b1;
                    opos_next     = SIZE_W'(cnt_reg + 1'b1);
                    oval_next     = och_digit_reg[0];
                    olast_next    = (SIZE_W'(cnt_reg + 1'b1) == n_eff);
                    odone_next    = 1'b0;
                    och_pop       = 1'b1;
                    stk_cmd.op    = STK_PUSH;
                    stk_cmd.top   = '{digit: och_digit_reg[0], fresh: och_fresh_reg[0],
                                      occ: 1'b1};
                    stk_cmd.under = stk_top;
                    cnt_next      = SIZE_W'(cnt_reg + 1'b1);
                    if (SIZE_W'(cnt_reg + 1'b1) == n_eff)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    opos_next   = '0;
                    oval_next   = '0;
                    olast_next  = 1'b1;
                    odone_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr_en)
        begin
            init_next = 1'b1;
            exh_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            lvl_reg    <= SIZE_W'(1);
            miss_reg   <= '0;
            cnt_reg    <= '0;
            init_reg   <= 1'b1;
            exh_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lvl_reg    <= lvl_next;
            miss_reg   <= miss_next;
            cnt_reg    <= cnt_next;
            init_reg   <= init_next;
            exh_reg    <= exh_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opos_reg  <= opos_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
        odone_reg <= odone_next;
    end

    always_ff @(posedge clk)
    begin
        if (och_push)
        begin
            och_digit_reg[0] <= stk_top.digit;
            och_fresh_reg[0] <= stk_top.fresh;
            for (int k = 1; k < MAX_DOMAIN; k++)
            begin
                och_digit_reg[k] <= och_digit_reg[k-1];
                och_fresh_reg[k] <= och_fresh_reg[k-1];
            end
        end
        else if (och_pop)
        begin
            for (int k = 0; k < MAX_DOMAIN - 1; k++)
            begin
                och_digit_reg[k] <= och_digit_reg[k+1];
                och_fresh_reg[k] <= och_fresh_reg[k+1];
            end
            och_digit_reg[MAX_DOMAIN-1] <= '0;
            och_fresh_reg[MAX_DOMAIN-1] <= 1'b0;
        end
    end

    assign out_valid     = ovalid_reg;
    assign position      = opos_reg;
    assign image_value   = oval_reg;
    assign last_of_tuple = olast_reg;
    assign done_res      = odone_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (lvl_reg <= n_eff))
        else $error("search level exceeds the tuple length");

    a_miss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (miss_reg <= m_eff))
        else $error("missing-value count exceeds the codomain size");

    a_top_occ: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SEARCH) && (lvl_reg != '0)) |-> stk_top.occ)
        else $error("current level cell is not occupied");

    a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (cnt_reg < n_eff))
        else $error("emit counter ran past the tuple length");

    a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (last_of_tuple && (position == '0)
                                     && (image_value == '0)))
        else $error("done beat carries tuple data");

endmodule
